// ----- src/ssc_pkg.sv -----
// Shared constants, status codes, register map and CRC helper for the slot classifier.
package ssc_pkg;

	// Slot geometry
	localparam int MAX_SLOT_BYTES   = 256;
	localparam int HEADER_BYTES     = 16;
	localparam int CRC_HEADER_BYTES = 12;
	localparam int FWD_REM_AT       = 32;
	localparam int REV_REM_AT       = 36;

	// Byte counter saturates one past the largest slot
	localparam int CNT_SAT = MAX_SLOT_BYTES + 1;
	localparam int CNT_W   = $clog2(CNT_SAT + 1);

	// Field widths
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 4;
	localparam int CRC_W    = 32;
	localparam int LEN_W    = 16;
	localparam int LIMIT_W  = 33;

	// Reflected CRC-32
	localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

	// Configuration port
	localparam int APB_ADDR_W = 6;
	localparam int APB_DATA_W = 64;
	localparam int REG_SEL_W  = 3;
	localparam logic [REG_SEL_W-1:0] REG_MAGIC        = 3'd0;
	localparam logic [REG_SEL_W-1:0] REG_COMMIT       = 3'd1;
	localparam logic [REG_SEL_W-1:0] REG_TYPE         = 3'd2;
	localparam logic [REG_SEL_W-1:0] REG_SCHEMA       = 3'd3;
	localparam logic [REG_SEL_W-1:0] REG_PAYLOAD_SIZE = 3'd4;
	localparam logic [REG_SEL_W-1:0] REG_CHECK_REM    = 3'd5;
	localparam logic [REG_SEL_W-1:0] REG_REM_LIMIT    = 3'd6;
	localparam logic [LIMIT_W-1:0]   REM_LIMIT_RESET  = 33'h1_0000_0000;

	// Classification codes
	localparam logic [STATUS_W-1:0] ST_EMPTY       = 4'd0;
	localparam logic [STATUS_W-1:0] ST_UNCOMMITTED = 4'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_MAGIC   = 4'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_TYPE    = 4'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_LENGTH  = 4'd4;
	localparam logic [STATUS_W-1:0] ST_BAD_CRC     = 4'd5;
	localparam logic [STATUS_W-1:0] ST_BAD_RSVD    = 4'd6;
	localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 4'd7;
	localparam logic [STATUS_W-1:0] ST_BAD_PAYLOAD = 4'd8;
	localparam logic [STATUS_W-1:0] ST_VALID       = 4'd9;

	// Fold one byte into a reflected CRC-32, LSB first
	function automatic logic [CRC_W-1:0] crc_fold_byte(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
		for (int k = 0; k < BYTE_W; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ----- src/ssc_if.sv -----
// Valid/ready channel interfaces for slot bytes in and classifications out.
interface ssc_in_if;
	logic                       valid;
	logic                       ready;
	logic [ssc_pkg::BYTE_W-1:0] slot_byte;
	logic                       last_byte;

	modport source (output valid, output slot_byte, output last_byte, input ready);
	modport sink (input valid, input slot_byte, input last_byte, output ready);
endinterface

interface ssc_out_if;
	logic                         valid;
	logic                         ready;
	logic [ssc_pkg::STATUS_W-1:0] status;
	logic [ssc_pkg::CRC_W-1:0]    computed_crc;
	logic [ssc_pkg::LEN_W-1:0]    decl_length;

	modport source (output valid, output status, output computed_crc, output decl_length,
		input ready);
	modport sink (input valid, input status, input computed_crc, input decl_length,
		output ready);
endinterface

// ----- src/storage_slot_classifier.sv -----
// Top level: byte-stream record slot classifier with APB configuration.
//
// Slot bytes enter on in_ch, offset 0 first, one item per byte; last_byte marks
// the commit byte. For each commit byte one item leaves on out_ch with the
// status code, the CRC-32 over header bytes 0..11 plus the declared payload
// (zero when it does not fit), and the declared payload length. All other
// bytes produce no output item. Throughput: one byte per cycle, including
// back-to-back slots, while no commit byte waits on a stalled out_ch.
// A commit byte passes through the input register, then the update/classify
// logic into the output register. The byte-serial CRC fold and the per-slot
// state update are combinational logic behind the input register.
// While out_ch stalls, non-commit bytes keep flowing into the per-slot state;
// a commit byte waits in the input register and in_ch.ready drops only then.
// Reset (arst_n low) clears the slot state, empties both registers and sets
// the configuration to its defaults (remainder limit 2^32, others zero).
// Configuration registers sit at byte address 8*i on the APB port and are
// to be written only while no slot is in flight.
module storage_slot_classifier (
	input  logic                             clk,
	input  logic                             arst_n,
	ssc_in_if.sink                           in_ch,
	ssc_out_if.source                        out_ch,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ssc_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [ssc_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [ssc_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);

	localparam int CW = ssc_pkg::CNT_W;
	localparam int PW = ssc_pkg::LEN_W + 1;

	// Configuration registers
	logic [31:0]                      magic_word_q;
	logic [7:0]                       commit_valid_value_q;
	logic [7:0]                       expected_type_q;
	logic [7:0]                       expected_schema_q;
	logic [7:0]                       expected_payload_size_q;
	logic                             check_remainders_q;
	logic [ssc_pkg::LIMIT_W-1:0]      remainder_limit_q;
	logic [ssc_pkg::REG_SEL_W-1:0]    reg_sel;
	logic                             cfg_wr;

	// Input register
	logic                             valid_s1;
	logic [ssc_pkg::BYTE_W-1:0]       byte_s1;
	logic                             last_s1;
	logic                             adv_s1;

	// Per-slot state
	logic [CW-1:0]                    byte_count_q;
	logic [ssc_pkg::CRC_W-1:0]        running_crc_q;
	logic                             seen_nonzero_q;
	logic [31:0]                      magic_seen_q;
	logic [7:0]                       type_seen_q;
	logic [7:0]                       schema_seen_q;
	logic [ssc_pkg::LEN_W-1:0]        length_seen_q;
	logic [31:0]                      stored_crc_q;
	logic                             reserved_dirty_q;
	logic [31:0]                      forward_rem_q;
	logic [31:0]                      reverse_rem_q;

	// Next-state values
	logic [CW-1:0]                    byte_count_n;
	logic [ssc_pkg::CRC_W-1:0]        running_crc_n;
	logic                             seen_nonzero_n;
	logic [31:0]                      magic_seen_n;
	logic [7:0]                       type_seen_n;
	logic [7:0]                       schema_seen_n;
	logic [ssc_pkg::LEN_W-1:0]        length_seen_n;
	logic [31:0]                      stored_crc_n;
	logic                             reserved_dirty_n;
	logic [31:0]                      forward_rem_n;
	logic [31:0]                      reverse_rem_n;

	// Classification
	logic                             in_window;
	logic [PW-1:0]                    idx_w;
	logic [PW-1:0]                    pend;
	logic                             size_ok;
	logic                             fits;
	logic [ssc_pkg::CRC_W-1:0]        crc_res;
	logic [ssc_pkg::STATUS_W-1:0]     status_res;

	// Output register
	logic                             out_valid_q;
	logic [ssc_pkg::STATUS_W-1:0]     status_q;
	logic [ssc_pkg::CRC_W-1:0]        crc_q;
	logic [ssc_pkg::LEN_W-1:0]        length_q;

	// APB decode
	assign pready  = 1'b1;
	assign reg_sel = paddr[ssc_pkg::APB_ADDR_W-1 -: ssc_pkg::REG_SEL_W];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_word_q            <= '0;
			commit_valid_value_q    <= '0;
			expected_type_q         <= '0;
			expected_schema_q       <= '0;
			expected_payload_size_q <= '0;
			check_remainders_q      <= 1'b0;
			remainder_limit_q       <= ssc_pkg::REM_LIMIT_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				ssc_pkg::REG_MAGIC:        magic_word_q            <= pwdata[31:0];
				ssc_pkg::REG_COMMIT:       commit_valid_value_q    <= pwdata[7:0];
				ssc_pkg::REG_TYPE:         expected_type_q         <= pwdata[7:0];
				ssc_pkg::REG_SCHEMA:       expected_schema_q       <= pwdata[7:0];
				ssc_pkg::REG_PAYLOAD_SIZE: expected_payload_size_q <= pwdata[7:0];
				ssc_pkg::REG_CHECK_REM:    check_remainders_q      <= pwdata[0];
				ssc_pkg::REG_REM_LIMIT:    remainder_limit_q <= pwdata[ssc_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (reg_sel)
			ssc_pkg::REG_MAGIC:        prdata = {32'h0, magic_word_q};
			ssc_pkg::REG_COMMIT:       prdata = {56'h0, commit_valid_value_q};
			ssc_pkg::REG_TYPE:         prdata = {56'h0, expected_type_q};
			ssc_pkg::REG_SCHEMA:       prdata = {56'h0, expected_schema_q};
			ssc_pkg::REG_PAYLOAD_SIZE: prdata = {56'h0, expected_payload_size_q};
			ssc_pkg::REG_CHECK_REM:    prdata = {63'h0, check_remainders_q};
			ssc_pkg::REG_REM_LIMIT:    prdata = {31'h0, remainder_limit_q};
			default:                   prdata = '0;
		endcase
	end

	// Handshake: only a commit byte can wait on a full output register
	assign adv_s1      = valid_s1 && (!last_s1 || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.slot_byte;
			last_s1 <= in_ch.last_byte;
		end
	end

	// Field capture and CRC fold for the byte in the input register
	always_comb begin
		in_window        = byte_count_q < CW'(ssc_pkg::MAX_SLOT_BYTES);
		seen_nonzero_n   = seen_nonzero_q;
		magic_seen_n     = magic_seen_q;
		type_seen_n      = type_seen_q;
		schema_seen_n    = schema_seen_q;
		length_seen_n    = length_seen_q;
		stored_crc_n     = stored_crc_q;
		forward_rem_n    = forward_rem_q;
		reverse_rem_n    = reverse_rem_q;
		running_crc_n    = running_crc_q;
		reserved_dirty_n = reserved_dirty_q;
		idx_w            = PW'(byte_count_q);
		pend             = '0;
		if (in_window) begin
			if (byte_s1 != '0) seen_nonzero_n = 1'b1;
			if (byte_count_q < CW'(4)) begin
				magic_seen_n[8*byte_count_q[1:0] +: 8] = magic_seen_q[8*byte_count_q[1:0] +: 8]
					| byte_s1;
			end else if (byte_count_q == CW'(4)) begin
				type_seen_n = byte_s1;
			end else if (byte_count_q == CW'(5)) begin
				schema_seen_n = byte_s1;
			end else if (byte_count_q == CW'(6)) begin
				length_seen_n[7:0] = length_seen_q[7:0] | byte_s1;
			end else if (byte_count_q == CW'(7)) begin
				length_seen_n[15:8] = length_seen_q[15:8] | byte_s1;
			end else if (byte_count_q >= CW'(ssc_pkg::CRC_HEADER_BYTES) &&
				byte_count_q < CW'(ssc_pkg::HEADER_BYTES)) begin
				stored_crc_n[8*byte_count_q[1:0] +: 8] = stored_crc_q[8*byte_count_q[1:0] +: 8]
					| byte_s1;
			end
			if (byte_count_q >= CW'(ssc_pkg::FWD_REM_AT) &&
				byte_count_q < CW'(ssc_pkg::FWD_REM_AT + 4)) begin
				forward_rem_n[8*byte_count_q[1:0] +: 8] = forward_rem_q[8*byte_count_q[1:0] +: 8]
					| byte_s1;
			end
			if (byte_count_q >= CW'(ssc_pkg::REV_REM_AT) &&
				byte_count_q < CW'(ssc_pkg::REV_REM_AT + 4)) begin
				reverse_rem_n[8*byte_count_q[1:0] +: 8] = reverse_rem_q[8*byte_count_q[1:0] +: 8]
					| byte_s1;
			end
			// Commit byte is neither folded nor checked as reserved
			pend = PW'(ssc_pkg::HEADER_BYTES) + {1'b0, length_seen_n};
			if (!last_s1) begin
				if (byte_count_q < CW'(ssc_pkg::CRC_HEADER_BYTES) ||
					(byte_count_q >= CW'(ssc_pkg::HEADER_BYTES) && idx_w < pend)) begin
					running_crc_n = ssc_pkg::crc_fold_byte(running_crc_q, byte_s1);
				end
				if (byte_count_q >= CW'(ssc_pkg::HEADER_BYTES) && idx_w >= pend &&
					byte_s1 != '0) begin
					reserved_dirty_n = 1'b1;
				end
			end
		end
		byte_count_n = (byte_count_q < CW'(ssc_pkg::CNT_SAT)) ? byte_count_q + CW'(1)
			: byte_count_q;
	end

	// Classification at the commit byte
	always_comb begin
		size_ok = byte_count_q >= CW'(ssc_pkg::HEADER_BYTES) &&
			byte_count_q < CW'(ssc_pkg::MAX_SLOT_BYTES);
		fits    = size_ok &&
			({1'b0, length_seen_n} + PW'(ssc_pkg::HEADER_BYTES) <= idx_w);
		crc_res = fits ? ~running_crc_q : '0;
		if (!size_ok) begin
			status_res = ssc_pkg::ST_BAD_LENGTH;
		end else if (!seen_nonzero_n) begin
			status_res = ssc_pkg::ST_EMPTY;
		end else if (byte_s1 != commit_valid_value_q) begin
			status_res = ssc_pkg::ST_UNCOMMITTED;
		end else if (magic_seen_n != magic_word_q) begin
			status_res = ssc_pkg::ST_BAD_MAGIC;
		end else if (type_seen_n != expected_type_q) begin
			status_res = ssc_pkg::ST_BAD_TYPE;
		end else if (!fits) begin
			status_res = ssc_pkg::ST_BAD_LENGTH;
		end else if (stored_crc_n != crc_res) begin
			status_res = ssc_pkg::ST_BAD_CRC;
		end else if (reserved_dirty_n) begin
			status_res = ssc_pkg::ST_BAD_RSVD;
		end else if (schema_seen_n != expected_schema_q) begin
			status_res = ssc_pkg::ST_UNSUPPORTED;
		end else if (length_seen_n != {8'h0, expected_payload_size_q}) begin
			status_res = ssc_pkg::ST_BAD_LENGTH;
		end else if (check_remainders_q &&
			({1'b0, forward_rem_n} >= remainder_limit_q ||
			 {1'b0, reverse_rem_n} >= remainder_limit_q)) begin
			status_res = ssc_pkg::ST_BAD_PAYLOAD;
		end else begin
			status_res = ssc_pkg::ST_VALID;
		end
	end

	// Slot state: advance on each byte, clear after the commit byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q     <= '0;
			running_crc_q    <= ssc_pkg::CRC_INIT;
			seen_nonzero_q   <= 1'b0;
			magic_seen_q     <= '0;
			type_seen_q      <= '0;
			schema_seen_q    <= '0;
			length_seen_q    <= '0;
			stored_crc_q     <= '0;
			reserved_dirty_q <= 1'b0;
			forward_rem_q    <= '0;
			reverse_rem_q    <= '0;
		end else if (adv_s1) begin
			if (last_s1) begin
				byte_count_q     <= '0;
				running_crc_q    <= ssc_pkg::CRC_INIT;
				seen_nonzero_q   <= 1'b0;
				magic_seen_q     <= '0;
				type_seen_q      <= '0;
				schema_seen_q    <= '0;
				length_seen_q    <= '0;
				stored_crc_q     <= '0;
				reserved_dirty_q <= 1'b0;
				forward_rem_q    <= '0;
				reverse_rem_q    <= '0;
			end else begin
				byte_count_q     <= byte_count_n;
				running_crc_q    <= running_crc_n;
				seen_nonzero_q   <= seen_nonzero_n;
				magic_seen_q     <= magic_seen_n;
				type_seen_q      <= type_seen_n;
				schema_seen_q    <= schema_seen_n;
				length_seen_q    <= length_seen_n;
				stored_crc_q     <= stored_crc_n;
				reserved_dirty_q <= reserved_dirty_n;
				forward_rem_q    <= forward_rem_n;
				reverse_rem_q    <= reverse_rem_n;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			status_q <= status_res;
			crc_q    <= crc_res;
			length_q <= length_seen_n;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.status       = status_q;
	assign out_ch.computed_crc = crc_q;
	assign out_ch.decl_length  = length_q;

endmodule

// ----- src/ssc_checker.sv -----
// Port-level checker for the slot classifier, bound to the top level.
module ssc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [ssc_pkg::STATUS_W-1:0]     status,
	input logic [ssc_pkg::CRC_W-1:0]        computed_crc,
	input logic [ssc_pkg::LEN_W-1:0]        decl_length
);

	// A stalled result item holds its contents
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
			$stable(computed_crc) && $stable(decl_length))
		else $error("result item changed while stalled");

	// With no result pending the byte input never stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	// Status codes stay within the defined set
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ssc_pkg::ST_VALID)
		else $error("undefined status code");

	// A valid slot's payload fits inside the largest slot
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ssc_pkg::ST_VALID |->
			decl_length <= ssc_pkg::LEN_W'(ssc_pkg::MAX_SLOT_BYTES - ssc_pkg::HEADER_BYTES - 1))
		else $error("valid slot with oversized payload");

	// An all-zero slot declares no payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ssc_pkg::ST_EMPTY |-> decl_length == '0)
		else $error("empty slot with nonzero length");

endmodule

bind storage_slot_classifier ssc_checker u_ssc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.status       (out_ch.status),
	.computed_crc (out_ch.computed_crc),
	.decl_length  (out_ch.decl_length)
);

// ----- sim/tb_top.sv -----
// Self-checking testbench for the storage slot classifier: slot traffic, APB setup, result scoring.
`timescale 1ns / 100ps

module tb_top;
	import ssc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	// One classification as it leaves the block
	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [CRC_W-1:0]    crc;
		logic [LEN_W-1:0]    plen;
	} verdict_t;

	typedef enum {
		SLOT_GOOD, SLOT_COMMIT, SLOT_MAGIC, SLOT_TYPE, SLOT_OVERRUN, SLOT_CRC,
		SLOT_RSVD, SLOT_SCHEMA, SLOT_PLEN, SLOT_ZERO, SLOT_NOISE, SLOT_HUGE
	} slot_kind_e;

	// Tracks the slot in flight and the classifications still owed by the block
	class slot_verdict_board;
		logic [31:0]        magic_cfg;
		logic [7:0]         commit_cfg;
		logic [7:0]         type_cfg;
		logic [7:0]         schema_cfg;
		logic [7:0]         psize_cfg;
		logic               chk_cfg;
		logic [LIMIT_W-1:0] limit_cfg;

		int unsigned        byte_idx;
		logic [CRC_W-1:0]   crc_acc;
		logic               nonzero;
		logic [31:0]        magic_acc;
		logic [7:0]         type_acc;
		logic [7:0]         schema_acc;
		logic [LEN_W-1:0]   len_acc;
		logic [31:0]        stored_acc;
		logic               dirty;
		logic [31:0]        fwd_acc;
		logic [31:0]        rev_acc;

		verdict_t pending[$];
		int       mismatches;
		int       verdicts;
		int       tally[10];

		function new();
			magic_cfg = '0;
			commit_cfg = '0;
			type_cfg = '0;
			schema_cfg = '0;
			psize_cfg = '0;
			chk_cfg = 1'b0;
			limit_cfg = REM_LIMIT_RESET;
			clear_slot();
		endfunction

		function void clear_slot();
			byte_idx = 0;
			crc_acc = '1;
			nonzero = 1'b0;
			magic_acc = '0;
			type_acc = '0;
			schema_acc = '0;
			len_acc = '0;
			stored_acc = '0;
			dirty = 1'b0;
			fwd_acc = '0;
			rev_acc = '0;
		endfunction

		// Reflected CRC-32, one bit per step
		static function logic [CRC_W-1:0] crc_step(logic [CRC_W-1:0] c, logic [7:0] b);
			logic [CRC_W-1:0] r;
			r = c;
			for (int k = 0; k < 8; k++) begin
				r = (r >> 1) ^ (CRC_POLY & {CRC_W{r[0] ^ b[k]}});
			end
			return r;
		endfunction

		// Fold one accepted byte; on the commit byte queue the expected verdict
		function void note_byte(logic [7:0] b, logic last);
			int unsigned idx;
			int unsigned fill_end;
			int unsigned nbytes;
			bit fits;
			logic [CRC_W-1:0] crc_out;
			verdict_t v;
			idx = byte_idx;
			if (idx < MAX_SLOT_BYTES) begin
				if (b != 0) nonzero = 1'b1;
				if (idx < 4) magic_acc |= 32'(b) << (8 * idx);
				else if (idx == 4) type_acc = b;
				else if (idx == 5) schema_acc = b;
				else if (idx == 6) len_acc |= 16'(b);
				else if (idx == 7) len_acc |= 16'(b) << 8;
				else if (idx >= CRC_HEADER_BYTES && idx < HEADER_BYTES)
					stored_acc |= 32'(b) << (8 * (idx - CRC_HEADER_BYTES));
				if (idx >= FWD_REM_AT && idx < FWD_REM_AT + 4)
					fwd_acc |= 32'(b) << (8 * (idx - FWD_REM_AT));
				if (idx >= REV_REM_AT && idx < REV_REM_AT + 4)
					rev_acc |= 32'(b) << (8 * (idx - REV_REM_AT));
				// commit byte is neither folded nor checked as tail
				if (!last) begin
					fill_end = HEADER_BYTES + len_acc;
					if (idx < CRC_HEADER_BYTES || (idx >= HEADER_BYTES && idx < fill_end))
						crc_acc = crc_step(crc_acc, b);
					else if (idx >= HEADER_BYTES && b != 0)
						dirty = 1'b1;
				end
			end
			if (!last) begin
				if (byte_idx < CNT_SAT) byte_idx++;
				return;
			end

			nbytes = idx + 1;
			fits = nbytes >= HEADER_BYTES + 1 && nbytes <= MAX_SLOT_BYTES &&
				len_acc + HEADER_BYTES + 1 <= nbytes;
			crc_out = fits ? ~crc_acc : '0;

			// priority cascade of the checks
			if (nbytes < HEADER_BYTES + 1 || nbytes > MAX_SLOT_BYTES) v.status = ST_BAD_LENGTH;
			else if (!nonzero) v.status = ST_EMPTY;
			else if (b != commit_cfg) v.status = ST_UNCOMMITTED;
			else if (magic_acc != magic_cfg) v.status = ST_BAD_MAGIC;
			else if (type_acc != type_cfg) v.status = ST_BAD_TYPE;
			else if (!fits) v.status = ST_BAD_LENGTH;
			else if (stored_acc != crc_out) v.status = ST_BAD_CRC;
			else if (dirty) v.status = ST_BAD_RSVD;
			else if (schema_acc != schema_cfg) v.status = ST_UNSUPPORTED;
			else if (len_acc != 16'(psize_cfg)) v.status = ST_BAD_LENGTH;
			else if (chk_cfg && ({1'b0, fwd_acc} >= limit_cfg || {1'b0, rev_acc} >= limit_cfg))
				v.status = ST_BAD_PAYLOAD;
			else v.status = ST_VALID;
			v.crc = crc_out;
			v.plen = len_acc;
			pending.push_back(v);
			clear_slot();
		endfunction

		// Score one classification against the oldest one owed
		function void check_verdict(logic [STATUS_W-1:0] st, logic [CRC_W-1:0] crc,
			logic [LEN_W-1:0] plen);
			verdict_t v;
			if (pending.size() == 0) begin
				$error("classification with no slot pending: status %0d", st);
				mismatches++;
				return;
			end
			v = pending.pop_front();
			verdicts++;
			tally[v.status]++;
			if (st !== v.status) begin
				$error("status: expected %0d, got %0d", v.status, st);
				mismatches++;
			end
			if (crc !== v.crc) begin
				$error("computed_crc: expected %08h, got %08h", v.crc, crc);
				mismatches++;
			end
			if (plen !== v.plen) begin
				$error("decl_length: expected %0d, got %0d", v.plen, plen);
				mismatches++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	ssc_in_if  in_ch ();
	ssc_out_if out_ch ();

	slot_verdict_board sb;
	logic [7:0]        slot_img[$];
	int                in_gap_pct;
	int                out_stall_pct;
	int unsigned       cycle_count;
	int                bytes_sent;

	storage_slot_classifier u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Result side back-pressure
	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
	end

	// Accepted items on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				sb.note_byte(in_ch.slot_byte, in_ch.last_byte);
			if (out_ch.valid && out_ch.ready)
				sb.check_verdict(out_ch.status, out_ch.computed_crc, out_ch.decl_length);
		end
	end

	task automatic reg_write(logic [REG_SEL_W-1:0] sel, logic [APB_DATA_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 3'b000};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apply_settings(logic [31:0] magic, logic [7:0] commit, logic [7:0] typ,
		logic [7:0] schema, logic [7:0] psize, logic chk, logic [LIMIT_W-1:0] lim);
		reg_write(REG_MAGIC, 64'(magic));
		reg_write(REG_COMMIT, 64'(commit));
		reg_write(REG_TYPE, 64'(typ));
		reg_write(REG_SCHEMA, 64'(schema));
		reg_write(REG_PAYLOAD_SIZE, 64'(psize));
		reg_write(REG_CHECK_REM, 64'(chk));
		reg_write(REG_REM_LIMIT, 64'(lim));
		sb.magic_cfg = magic;
		sb.commit_cfg = commit;
		sb.type_cfg = typ;
		sb.schema_cfg = schema;
		sb.psize_cfg = psize;
		sb.chk_cfg = chk;
		sb.limit_cfg = lim;
	endtask

	task automatic send_byte(logic [7:0] b, logic last);
		@(negedge clk);
		while ($urandom_range(99) < in_gap_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.slot_byte <= b;
		in_ch.last_byte <= last;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic send_slot();
		foreach (slot_img[i]) send_byte(slot_img[i], i == slot_img.size() - 1);
		bytes_sent += slot_img.size();
	endtask

	// Stop sending and wait for every owed classification, then let the pipe settle
	task automatic wait_drained();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Remainder value around the current limit
	function automatic logic [31:0] pick_rem();
		logic [LIMIT_W-1:0] lim;
		lim = sb.limit_cfg;
		case ($urandom_range(3))
			0: return $urandom;
			1: return (lim == 0) ? 32'd0 : 32'(lim - 1);
			2: return 32'(lim);
			default: return (lim == 0 || lim > 33'hFFFF_FFFF) ? $urandom :
				$urandom_range(32'(lim - 1), 0);
		endcase
	endfunction

	// Build one slot image; size_hint of 0 lets the kind choose the length
	function automatic void make_slot(slot_kind_e kind, int size_hint);
		int nbytes;
		int plen;
		int tail;
		logic [31:0] crc;
		logic [31:0] rem;
		logic [15:0] bad_len;
		logic [7:0] flip;
		slot_img.delete();
		flip = 8'($urandom_range(255, 1));

		// unstructured slots
		if (kind == SLOT_ZERO || kind == SLOT_NOISE || kind == SLOT_HUGE) begin
			if (size_hint != 0) nbytes = size_hint;
			else if (kind == SLOT_HUGE) nbytes = $urandom_range(300, 257);
			else if (kind == SLOT_ZERO) nbytes = $urandom_range(48, 17);
			else nbytes = ($urandom_range(4) != 0) ? $urandom_range(40, 1) : $urandom_range(256, 1);
			repeat (nbytes) slot_img.push_back(kind == SLOT_ZERO ? 8'h00 : 8'($urandom));
			return;
		end

		plen = (kind == SLOT_PLEN) ? $urandom_range(40, 0) : int'(sb.psize_cfg);
		tail = ($urandom_range(19) == 0 && plen < 239) ? $urandom_range(239 - plen, 0) :
			$urandom_range(6, 0);
		if (kind == SLOT_RSVD && tail == 0) tail = 1;

		// header, payload, zero tail, commit
		for (int k = 0; k < 4; k++) slot_img.push_back(sb.magic_cfg[8*k +: 8]);
		slot_img.push_back(sb.type_cfg);
		slot_img.push_back(sb.schema_cfg);
		slot_img.push_back(8'(plen));
		slot_img.push_back(8'(plen >> 8));
		repeat (4) slot_img.push_back(8'($urandom));
		repeat (4) slot_img.push_back(8'h00);
		repeat (plen) slot_img.push_back(8'($urandom));
		repeat (tail) slot_img.push_back(8'h00);
		slot_img.push_back(sb.commit_cfg);

		if (plen >= 24) begin
			rem = pick_rem();
			for (int k = 0; k < 4; k++) slot_img[FWD_REM_AT + k] = rem[8*k +: 8];
			rem = pick_rem();
			for (int k = 0; k < 4; k++) slot_img[REV_REM_AT + k] = rem[8*k +: 8];
		end
		if (kind == SLOT_SCHEMA) slot_img[5] ^= flip;
		if (kind == SLOT_RSVD) slot_img[16 + plen + $urandom_range(tail - 1, 0)] = flip;

		// stamp the header CRC
		crc = CRC_INIT;
		for (int k = 0; k < CRC_HEADER_BYTES; k++)
			crc = slot_verdict_board::crc_step(crc, slot_img[k]);
		for (int k = 0; k < plen; k++)
			crc = slot_verdict_board::crc_step(crc, slot_img[HEADER_BYTES + k]);
		crc = ~crc;
		for (int k = 0; k < 4; k++) slot_img[CRC_HEADER_BYTES + k] = crc[8*k +: 8];

		// damage after the CRC is in place
		case (kind)
			SLOT_COMMIT: slot_img[slot_img.size() - 1] ^= flip;
			SLOT_MAGIC: slot_img[$urandom_range(3, 0)] ^= flip;
			SLOT_TYPE: slot_img[4] ^= flip;
			SLOT_CRC: slot_img[$urandom_range(15, 8)] ^= flip;
			SLOT_OVERRUN: begin
				bad_len = ($urandom_range(3) == 0) ? 16'hFFFF :
					16'(slot_img.size() - 16 + $urandom_range(1000, 0));
				slot_img[6] = bad_len[7:0];
				slot_img[7] = bad_len[15:8];
			end
			default: ;
		endcase

		// forced length: cut or pad, commit byte kept at the end
		if (size_hint != 0) begin
			while (slot_img.size() > size_hint) void'(slot_img.pop_back());
			while (slot_img.size() < size_hint) slot_img.push_back(8'h00);
			slot_img[size_hint - 1] = sb.commit_cfg;
		end
	endfunction

	task automatic run_random_phase(int gap_pct, int stall_pct);
		int slots;
		int start_bytes;
		int r;
		in_gap_pct = gap_pct;
		out_stall_pct = stall_pct;
		slots = 0;
		start_bytes = bytes_sent;
		while (bytes_sent - start_bytes < 60 || slots < 3) begin
			r = $urandom_range(99);
			if (r < 40) make_slot(SLOT_GOOD, 0);
			else if (r < 45) make_slot(SLOT_COMMIT, 0);
			else if (r < 50) make_slot(SLOT_MAGIC, 0);
			else if (r < 55) make_slot(SLOT_TYPE, 0);
			else if (r < 60) make_slot(SLOT_OVERRUN, 0);
			else if (r < 65) make_slot(SLOT_CRC, 0);
			else if (r < 70) make_slot(SLOT_RSVD, 0);
			else if (r < 75) make_slot(SLOT_SCHEMA, 0);
			else if (r < 80) make_slot(SLOT_PLEN, 0);
			else if (r < 83) make_slot(SLOT_ZERO, 0);
			else if (r < 91) make_slot(SLOT_NOISE, 0);
			else if (r < 93) make_slot(SLOT_HUGE, 0);
			else if (r < 96) make_slot(SLOT_GOOD, $urandom_range(16, 1));
			else make_slot(SLOT_GOOD, $urandom_range(FWD_REM_AT + 8, FWD_REM_AT + 1));
			send_slot();
			slots++;
			// occasional full stop until the block has caught up
			if ($urandom_range(19) == 0) wait_drained();
		end
		wait_drained();
	endtask

	initial begin
		slot_kind_e flaw_list[9];
		string tally_line;
		sb = new();
		bytes_sent = 0;
		cycle_count = 0;
		in_gap_pct = 20;
		out_stall_pct = 20;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.slot_byte = '0;
		in_ch.last_byte = 1'b0;
		out_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: default registers, empty, tiny and oversize slots
		make_slot(SLOT_ZERO, HEADER_BYTES + 1);
		send_slot();
		make_slot(SLOT_GOOD, 0);
		send_slot();
		make_slot(SLOT_NOISE, 1);
		send_slot();
		make_slot(SLOT_HUGE, MAX_SLOT_BYTES + 4);
		send_slot();
		wait_drained();

		// directed: all-ones registers, largest slot and payload, zero remainder limit
		apply_settings('1, 8'hFF, 8'hFF, 8'hFF, 8'd239, 1'b1, '0);
		make_slot(SLOT_GOOD, MAX_SLOT_BYTES);
		send_slot();
		wait_drained();

		// directed: one slot per check, then short and remainder-area commits
		apply_settings(32'h5AA5_0FF0, 8'h81, 8'h12, 8'h34, 8'd24, 1'b1, 33'd1);
		flaw_list = '{SLOT_GOOD, SLOT_COMMIT, SLOT_MAGIC, SLOT_TYPE, SLOT_OVERRUN,
			SLOT_CRC, SLOT_RSVD, SLOT_SCHEMA, SLOT_PLEN};
		foreach (flaw_list[i]) begin
			make_slot(flaw_list[i], 0);
			send_slot();
		end
		make_slot(SLOT_GOOD, HEADER_BYTES);
		send_slot();
		make_slot(SLOT_GOOD, REV_REM_AT);
		send_slot();
		make_slot(SLOT_GOOD, FWD_REM_AT + 8);
		send_slot();
		wait_drained();

		// random: sender mostly busy, receiver mostly stalled
		apply_settings($urandom, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom_range(20, 0)), 1'b0, REM_LIMIT_RESET);
		run_random_phase(14, 79);

		// random: sender mostly idle, remainder check on
		apply_settings($urandom, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom_range(40, 24)), 1'b1, {1'b0, $urandom});
		run_random_phase(79, 14);

		// random, no idling: zero registers, widest limit
		apply_settings('0, '0, '0, '0, 8'd24, 1'b1, REM_LIMIT_RESET);
		run_random_phase(0, 0);

		// random, no idling: small limit
		apply_settings($urandom, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom_range(32, 24)), 1'b1, 33'($urandom_range(65535, 0)));
		run_random_phase(0, 0);

		wait_drained();
		tally_line = "";
		foreach (sb.tally[i]) tally_line = {tally_line, $sformatf(" %0d", sb.tally[i])};
		$display("Run covered %0d slot bytes and %0d classified slots under seven register sets.",
			bytes_sent, sb.verdicts);
		$display("Verdicts by status code 0..9:%s", tally_line);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/ssc_pkg.sv
src/ssc_if.sv
src/storage_slot_classifier.sv
src/ssc_checker.sv
sim/tb_top.sv
